[hdl/lhad_pkg.sv]
// types, register indexes and helper functions for the lux hysteresis auto-dimmer
// no dependencies; imported by lux_hysteresis_auto_dimmer
package lhad_pkg;

   // field widths
   localparam int LuxW    = 24;
   localparam int PctW    = 7;
   localparam int StreakW = 5;
   localparam int PresetW = 3;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 24;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_DIM_ENABLE  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_NIGHT_ENTER = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DAY_EXIT    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_NIGHT_DIM   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_REQ_SAMPLES = 3'd4;

   // configuration reset values
   localparam logic              RST_DIM_ENABLE  = 1'b1;
   localparam logic [LuxW-1:0]   RST_NIGHT_ENTER = 24'd500;
   localparam logic [LuxW-1:0]   RST_DAY_EXIT    = 24'd1500;
   localparam logic [PctW-1:0]   RST_NIGHT_DIM   = 7'd10;
   localparam logic [StreakW-1:0] RST_REQ_SAMPLES = 5'd3;

   // operation codes
   localparam logic OP_SAMPLE    = 1'b0;
   localparam logic OP_RECOMPUTE = 1'b1;

   // constants
   localparam logic [StreakW-1:0] STREAK_MAX  = 5'd31;
   localparam logic [PctW-1:0]    PCT_MAX     = 7'd100;
   localparam logic [PresetW-1:0] PRESET_HIGH = 3'd4;

   typedef struct packed {
      logic            op;
      logic [LuxW-1:0] lux_centi;
      logic [PctW-1:0] user_pct;
   } req_type;

   typedef struct packed {
      logic [PctW-1:0]    shown_pct;
      logic               night_flag;
      logic               led_update;
      logic [PresetW-1:0] preset_level;
   } rsp_type;

   // preset bucket of a brightness percentage
   function automatic logic [PresetW-1:0] preset_of(input logic [PctW-1:0] pct);
      logic [PresetW-1:0] lvl;
      if (pct == 7'd0) begin
         lvl = 3'd0;
      end else if (pct <= 7'd10) begin
         lvl = 3'd1;
      end else if (pct <= 7'd30) begin
         lvl = 3'd2;
      end else if (pct <= 7'd60) begin
         lvl = 3'd3;
      end else begin
         lvl = PRESET_HIGH;
      end
      return lvl;
   endfunction

   // limit a percentage to 100
   function automatic logic [PctW-1:0] clamp_pct(input logic [PctW-1:0] pct);
      return (pct > PCT_MAX) ? PCT_MAX : pct;
   endfunction

endpackage

[hdl/lux_hysteresis_auto_dimmer.sv]
// lux hysteresis auto-dimmer: debounced day/night detection and brightness selection
// depends on lhad_pkg
//
// input register, then result register; state is updated in the single pass between them
// throughput: one transaction per cycle while rsp_stall does not hold the result register
// reset: synchronous, active high; clears control state and loads configuration defaults
module lux_hysteresis_auto_dimmer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lhad_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lhad_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lhad_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [lhad_pkg::CsrDatW-1:0]        csr_wdata
);
   import lhad_pkg::*;

   // configuration registers
   logic               dim_enable_ff;
   logic [LuxW-1:0]    night_enter_ff;
   logic [LuxW-1:0]    day_exit_ff;
   logic [PctW-1:0]    night_dim_ff;
   logic [StreakW-1:0] req_samples_ff;

   // detector state
   logic               night_mode_ff,    night_mode_in;
   logic [StreakW-1:0] dark_streak_ff,   dark_streak_in;
   logic [StreakW-1:0] bright_streak_ff, bright_streak_in;
   logic [PctW-1:0]    applied_pct_ff,   applied_pct_in;
   logic               applied_valid_ff, applied_valid_in;

   // pipeline registers
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff, out_data_in;

   logic out_load;
   logic in_fire;

   // handshake
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign in_fire   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_enable_ff  <= RST_DIM_ENABLE;
         night_enter_ff <= RST_NIGHT_ENTER;
         day_exit_ff    <= RST_DAY_EXIT;
         night_dim_ff   <= RST_NIGHT_DIM;
         req_samples_ff <= RST_REQ_SAMPLES;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIM_ENABLE:  dim_enable_ff  <= csr_wdata[0];
            CSR_NIGHT_ENTER: night_enter_ff <= csr_wdata[LuxW-1:0];
            CSR_DAY_EXIT:    day_exit_ff    <= csr_wdata[LuxW-1:0];
            CSR_NIGHT_DIM:   night_dim_ff   <= csr_wdata[PctW-1:0];
            CSR_REQ_SAMPLES: req_samples_ff <= csr_wdata[StreakW-1:0];
            default: ;
         endcase
      end
   end

   // streaks, mode and brightness for the registered transaction
   always_comb begin
      logic [StreakW-1:0] need;
      logic [PctW-1:0]    cfg;
      logic [PctW-1:0]    target;
      logic               do_recompute;
      logic               pushed;

      night_mode_in    = night_mode_ff;
      dark_streak_in   = dark_streak_ff;
      bright_streak_in = bright_streak_ff;
      applied_pct_in   = applied_pct_ff;
      applied_valid_in = applied_valid_ff;
      cfg    = in_data_ff.user_pct;
      need   = (req_samples_ff == '0) ? 5'd1 : req_samples_ff;
      pushed = 1'b0;

      // debounced day/night detection
      if (in_data_ff.op == OP_SAMPLE && dim_enable_ff) begin
         if (in_data_ff.lux_centi < night_enter_ff) begin
            if (dark_streak_ff < STREAK_MAX) begin
               dark_streak_in = dark_streak_ff + 5'd1;
            end
            bright_streak_in = '0;
            if (dark_streak_in >= need) begin
               night_mode_in = 1'b1;
            end
         end else if (in_data_ff.lux_centi > day_exit_ff) begin
            if (bright_streak_ff < STREAK_MAX) begin
               bright_streak_in = bright_streak_ff + 5'd1;
            end
            dark_streak_in = '0;
            if (bright_streak_in >= need) begin
               night_mode_in = 1'b0;
            end
         end else begin
            dark_streak_in   = '0;
            bright_streak_in = '0;
         end
      end

      do_recompute = (in_data_ff.op == OP_RECOMPUTE) ||
                     (dim_enable_ff && (night_mode_in != night_mode_ff));

      // target brightness under the new mode
      if (!dim_enable_ff || !night_mode_in) begin
         target = cfg;
      end else if (cfg == '0 || preset_of(cfg) < PRESET_HIGH) begin
         target = '0;
      end else begin
         target = night_dim_ff;
      end
      target = clamp_pct(target);

      // push only a changed brightness
      if (do_recompute && !(applied_valid_ff && target == applied_pct_ff)) begin
         applied_pct_in   = target;
         applied_valid_in = 1'b1;
         pushed           = 1'b1;
      end

      out_data_in.shown_pct    = applied_valid_in ? applied_pct_in : clamp_pct(cfg);
      out_data_in.night_flag   = night_mode_in;
      out_data_in.led_update   = pushed;
      out_data_in.preset_level = preset_of(cfg);
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         night_mode_ff    <= 1'b0;
         dark_streak_ff   <= '0;
         bright_streak_ff <= '0;
         applied_pct_ff   <= '0;
         applied_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (in_fire) begin
            night_mode_ff    <= night_mode_in;
            dark_streak_ff   <= dark_streak_in;
            bright_streak_ff <= bright_streak_in;
            applied_pct_ff   <= applied_pct_in;
            applied_valid_ff <= applied_valid_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
      if (in_fire) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
